// ===== rtl/backproject_integral_image_unit_defines.svh =====
// Assertion macros shared by the backprojection integral image RTL.
`ifndef BACKPROJECT_INTEGRAL_IMAGE_UNIT_DEFINES_SVH
`define BACKPROJECT_INTEGRAL_IMAGE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BPII_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold.
`define BPII_ASSERT_NEVER(label, clk_s, rst_s, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/bpii_pkg.sv =====
// Package: types, constants and helpers of the backprojection integral image unit.
package bpii_pkg;

    localparam int MAX_WIDTH        = 1024;
    localparam int MAX_HEIGHT       = 1024;
    localparam int BINS_PER_CHANNEL = 8;
    localparam int SCORE_BITS       = 16;
    localparam int CHANNEL_DIVISOR  = 32;

    localparam int TABLE_DEPTH = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int BIN_BITS    = $clog2(BINS_PER_CHANNEL);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int SUM_BITS    = 36;
    localparam int CFG_BITS    = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = QUEUE_AW + 1;
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_AW         = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS   = OUT_AW + 1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic MODE_TABLE_WRITE = 1'b0;
    localparam logic MODE_PIXEL       = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [8:0]         bin_index;
        logic signed [15:0] bin_score;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               frame_start;
    } bpii_in_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] integral_sum;
        logic                       row_end;
        logic                       frame_end;
    } bpii_out_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic                  is_pixel;
        logic [TABLE_AW-1:0]   addr;
        logic [SCORE_BITS-1:0] score;
        logic [COL_BITS-1:0]   col;
        logic                  row_zero;
        logic                  row_end;
        logic                  frame_end;
    } bpii_cmd_t;

    function automatic logic [BIN_BITS-1:0] channel_bin(input logic [7:0] c);
        logic [7:0] q;
        q = 8'(c / CHANNEL_DIVISOR);
        if (q > 8'(BINS_PER_CHANNEL - 1)) begin
            q = 8'(BINS_PER_CHANNEL - 1);
        end
        return BIN_BITS'(q);
    endfunction

    function automatic logic [TABLE_AW-1:0] pixel_bin(input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
        logic [TABLE_AW-1:0] rb;
        logic [TABLE_AW-1:0] gb;
        logic [TABLE_AW-1:0] bb;
        rb = TABLE_AW'(channel_bin(r));
        gb = TABLE_AW'(channel_bin(g));
        bb = TABLE_AW'(channel_bin(b));
        return TABLE_AW'(rb * TABLE_AW'(BINS_PER_CHANNEL * BINS_PER_CHANNEL)
                         + gb * TABLE_AW'(BINS_PER_CHANNEL) + bb);
    endfunction

endpackage

// ===== rtl/bpii_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpii_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bpii_queue.sv =====
// Short command queue between the front and back parts.
`include "backproject_integral_image_unit_defines.svh"

module bpii_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  bpii_pkg::bpii_cmd_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output bpii_pkg::bpii_cmd_t rd_data,
    output logic                valid
);

    bpii_pkg::bpii_cmd_t mem_reg [bpii_pkg::QUEUE_DEPTH];
    logic [bpii_pkg::QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bpii_pkg::QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bpii_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;

    assign full    = (count_reg == bpii_pkg::QUEUE_CNT_BITS'(bpii_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg
                    + bpii_pkg::QUEUE_CNT_BITS'(wr_en)
                    - bpii_pkg::QUEUE_CNT_BITS'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `BPII_ASSERT_IMPLY(a_queue_no_underflow, clk, rst_n, rd_en, count_reg != '0, "queue read while empty")
    `BPII_ASSERT_IMPLY(a_queue_no_overflow, clk, rst_n, wr_en, (count_reg != bpii_pkg::QUEUE_CNT_BITS'(bpii_pkg::QUEUE_DEPTH)) || rd_en, "queue written while full")

endmodule

// ===== rtl/bpii_front.sv =====
// Front part: config registers, item acceptance, bin and raster position classification.
module bpii_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [bpii_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bpii_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                  push,
    input  bpii_pkg::bpii_in_t                    in_item,
    input  logic                                  q_full,
    output logic                                  q_wr,
    output bpii_pkg::bpii_cmd_t                   q_cmd
);

    logic [bpii_pkg::CFG_BITS-1:0] width_reg, width_next;
    logic [bpii_pkg::CFG_BITS-1:0] height_reg, height_next;
    logic [bpii_pkg::COL_BITS-1:0] col_reg, col_next;
    logic [bpii_pkg::ROW_BITS-1:0] row_reg, row_next;

    logic                          is_pixel;
    logic [bpii_pkg::COL_BITS-1:0] col_cur;
    logic [bpii_pkg::ROW_BITS-1:0] row_cur;
    logic [bpii_pkg::CFG_BITS-1:0] w_eff, h_eff;
    logic                          row_end, frame_end;

    assign q_wr     = push && !q_full;
    assign is_pixel = (in_item.mode == bpii_pkg::MODE_PIXEL);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bpii_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                bpii_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..max.
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
        begin
            w_eff = bpii_pkg::CFG_BITS'(1);
        end
        else if (width_reg > bpii_pkg::CFG_BITS'(bpii_pkg::MAX_WIDTH))
        begin
            w_eff = bpii_pkg::CFG_BITS'(bpii_pkg::MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg == '0)
        begin
            h_eff = bpii_pkg::CFG_BITS'(1);
        end
        else if (height_reg > bpii_pkg::CFG_BITS'(bpii_pkg::MAX_HEIGHT))
        begin
            h_eff = bpii_pkg::CFG_BITS'(bpii_pkg::MAX_HEIGHT);
        end
    end

    always_comb
    begin
        col_cur   = in_item.frame_start ? '0 : col_reg;
        row_cur   = in_item.frame_start ? '0 : row_reg;
        row_end   = bpii_pkg::CFG_BITS'(col_cur) >= (w_eff - 1'b1);
        frame_end = row_end && (bpii_pkg::CFG_BITS'(row_cur) >= (h_eff - 1'b1));

        col_next = col_reg;
        row_next = row_reg;
        if (q_wr && is_pixel)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_cur + 1'b1;
            end
            else
            begin
                col_next = col_cur + 1'b1;
                row_next = row_cur;
            end
        end
    end

    always_comb
    begin
        q_cmd.is_pixel  = is_pixel;
        q_cmd.addr      = is_pixel
                        ? bpii_pkg::pixel_bin(in_item.red, in_item.green, in_item.blue)
                        : bpii_pkg::TABLE_AW'(in_item.bin_index);
        q_cmd.score     = bpii_pkg::SCORE_BITS'(in_item.bin_score);
        q_cmd.col       = col_cur;
        q_cmd.row_zero  = (row_cur == '0);
        q_cmd.row_end   = row_end;
        q_cmd.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bpii_pkg::WIDTH_RESET;
            height_reg <= bpii_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== rtl/bpii_back.sv =====
// Back part: score lookup, row accumulation, line store update and result queue.
`include "backproject_integral_image_unit_defines.svh"

module bpii_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  bpii_pkg::bpii_cmd_t q_cmd,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output bpii_pkg::bpii_out_t out_item
);

    logic [bpii_pkg::OUT_CNT_BITS-1:0] in_flight;
    logic                              issue_pixel;
    logic                              table_we;
    logic [bpii_pkg::SCORE_BITS-1:0]   score_rdata;
    logic [bpii_pkg::SUM_BITS-1:0]     line_rdata;

    // Stage 1: RAM data arrives
    logic                          s1_valid_reg;
    logic [bpii_pkg::COL_BITS-1:0] s1_col_reg;
    logic                          s1_row_zero_reg;
    logic                          s1_row_end_reg;
    logic                          s1_frame_end_reg;
    logic                          s1_fwd_reg, s1_fwd_next;

    logic [bpii_pkg::SUM_BITS-1:0] row_total_reg;
    logic [bpii_pkg::SUM_BITS-1:0] last_sum_reg;
    logic [bpii_pkg::SUM_BITS-1:0] score_ext, base, row_sum, above, sum;

    // Result queue
    bpii_pkg::bpii_out_t               out_mem_reg [bpii_pkg::OUT_DEPTH];
    logic [bpii_pkg::OUT_AW-1:0]       out_wr_ptr_reg;
    logic [bpii_pkg::OUT_AW-1:0]       out_rd_ptr_reg;
    logic [bpii_pkg::OUT_CNT_BITS-1:0] out_count_reg, out_count_next;
    logic                              out_pop;

    // Pixels only issue when the result queue has a slot reserved.
    assign in_flight   = out_count_reg + bpii_pkg::OUT_CNT_BITS'(s1_valid_reg);
    assign issue_pixel = q_valid && q_cmd.is_pixel
                       && (in_flight < bpii_pkg::OUT_CNT_BITS'(bpii_pkg::OUT_DEPTH));
    assign table_we    = q_valid && !q_cmd.is_pixel;
    assign q_pop       = issue_pixel || table_we;

    // Same column written last cycle: RAM read is stale, take the fresh sum.
    assign s1_fwd_next = issue_pixel && s1_valid_reg && (q_cmd.col == s1_col_reg);

    bpii_ram #(
        .WIDTH(bpii_pkg::SCORE_BITS),
        .DEPTH(bpii_pkg::TABLE_DEPTH)
    ) u_score_ram (
        .clk  (clk),
        .we   (table_we),
        .waddr(q_cmd.addr),
        .wdata(q_cmd.score),
        .raddr(q_cmd.addr),
        .rdata(score_rdata)
    );

    bpii_ram #(
        .WIDTH(bpii_pkg::SUM_BITS),
        .DEPTH(bpii_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk  (clk),
        .we   (s1_valid_reg),
        .waddr(s1_col_reg),
        .wdata(sum),
        .raddr(q_cmd.col),
        .rdata(line_rdata)
    );

    // Row total is zero at column zero by construction.
    always_comb
    begin
        score_ext = bpii_pkg::SUM_BITS'(signed'(score_rdata));
        base      = (s1_col_reg == '0) ? '0 : row_total_reg;
        row_sum   = base + score_ext;
        above     = s1_fwd_reg ? last_sum_reg : line_rdata;
        sum       = s1_row_zero_reg ? row_sum : row_sum + above;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_pixel;
            s1_fwd_reg   <= s1_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_pixel)
        begin
            s1_col_reg       <= q_cmd.col;
            s1_row_zero_reg  <= q_cmd.row_zero;
            s1_row_end_reg   <= q_cmd.row_end;
            s1_frame_end_reg <= q_cmd.frame_end;
        end
        if (s1_valid_reg)
        begin
            row_total_reg <= row_sum;
            last_sum_reg  <= sum;
        end
    end

    // Result queue
    assign empty    = (out_count_reg == '0);
    assign out_pop  = pop && !empty;
    assign out_item = out_mem_reg[out_rd_ptr_reg];

    always_comb
    begin
        out_count_next = out_count_reg
                       + bpii_pkg::OUT_CNT_BITS'(s1_valid_reg)
                       - bpii_pkg::OUT_CNT_BITS'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_mem_reg[out_wr_ptr_reg].integral_sum <= signed'(sum);
            out_mem_reg[out_wr_ptr_reg].row_end      <= s1_row_end_reg;
            out_mem_reg[out_wr_ptr_reg].frame_end    <= s1_frame_end_reg;
        end
    end

    `BPII_ASSERT_IMPLY(a_result_slot_reserved, clk, rst_n, s1_valid_reg, out_count_reg < bpii_pkg::OUT_CNT_BITS'(bpii_pkg::OUT_DEPTH), "result written with no free slot")
    `BPII_ASSERT_NEVER(a_out_count_bound, clk, rst_n, out_count_reg > bpii_pkg::OUT_CNT_BITS'(bpii_pkg::OUT_DEPTH), "result count past depth")
    `BPII_ASSERT_IMPLY(a_fwd_needs_pixel, clk, rst_n, s1_fwd_reg, s1_valid_reg, "line forward without a pixel in stage 1")

endmodule

// ===== rtl/backproject_integral_image_unit.sv =====
// Top level of the histogram backprojection integral image unit.
//
// Usage:
//   Input queue side: drive in_item and raise push; the transfer happens on a
//   clock edge where push is high and full is low. mode 0 items load one entry
//   of the 512-entry signed score table; mode 1 items are raster pixels.
//   Result queue side: while empty is low, out_item holds the oldest result
//   (integral_sum, row_end, frame_end); it transfers on an edge with pop high.
//   Table writes give no result; each pixel gives exactly one.
//   Config: cfg_write with cfg_index 0 (image_width) or 1 (image_height) and
//   cfg_data, written while the unit is idle.
// Timing:
//   One item per clock sustained while pop keeps the result queue from filling. A pixel's
//   result reaches out_item through the command queue, the RAM read, then the add.
//   The rate is bounded by one score RAM read and one line store read/write
//   per pixel, each on its own port.
// Reset: counters and queues clear; score table and line store contents are
//   undefined, so the table must be loaded before pixels that use it.
// Stall: if pop stays low, the result queue fills, the back part stops issuing
//   pixels, the command queue fills and full rises; nothing is dropped.
module backproject_integral_image_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  bpii_pkg::bpii_in_t                  in_item,
    output logic                                empty,
    input  logic                                pop,
    output bpii_pkg::bpii_out_t                 out_item,
    input  logic                                cfg_write,
    input  logic [bpii_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bpii_pkg::CFG_BITS-1:0]       cfg_data
);

    logic                q_wr;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    bpii_pkg::bpii_cmd_t q_wr_cmd;
    bpii_pkg::bpii_cmd_t q_rd_cmd;

    assign full = q_full;

    // Front: config, acceptance, bin and position classification.
    bpii_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_cmd    (q_wr_cmd)
    );

    // Decouples the front from back-side stalls.
    bpii_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_data(q_wr_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(q_rd_cmd),
        .valid  (q_valid)
    );

    // Back: table writes, lookup, row and column integration, results.
    bpii_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_rd_cmd),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .out_item(out_item)
    );

endmodule
